@@ rtl/assert_macros.svh @@
// Assertion helper macros for the LED twinkle/fade sequencer.
// Included by the RTL files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define LTFS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ltfs assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define LTFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ltfs assertion failed");

`endif

@@ rtl/ltfs_pkg.sv @@
// Shared types, codes and helpers of the LED twinkle/fade sequencer.
// No dependencies.
`default_nettype none

package ltfs_pkg;

   localparam logic [1:0] PH_STEADY = 2'd0;
   localparam logic [1:0] PH_DOWN   = 2'd1;
   localparam logic [1:0] PH_UP     = 2'd2;

   localparam logic [2:0] REG_BLINK_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_OFF_BASE_MS     = 3'd1;
   localparam logic [2:0] REG_ON_BASE_MS      = 3'd2;
   localparam logic [2:0] REG_RANDOM_SPAN_MS  = 3'd3;
   localparam logic [2:0] REG_MIN_BRIGHT      = 3'd4;
   localparam logic [2:0] REG_RESTART_MS      = 3'd5;

   localparam int CSR_ADDR_W = 5;

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] last_ms;
      logic [15:0] length_ms;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{phase: PH_UP, last_ms: 32'd0, length_ms: 16'd0};

   function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] bright);
      logic [16:0] prod;
      prod = {9'd0, c} * ({9'd0, bright} + 17'd1);
      return prod[15:8];
   endfunction

endpackage

`default_nettype wire

@@ rtl/ltfs_if.sv @@
// Request and response channel interfaces of the LED twinkle/fade sequencer.
// No dependencies.
`default_nettype none

interface ltfs_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  led_index;
   logic [31:0] now_ms;
   logic [15:0] rand_trigger;
   logic [15:0] rand_span;
   logic [23:0] base_color;

   modport source (output valid, func, led_index, now_ms, rand_trigger, rand_span, base_color,
                   input ready);
   modport sink (input valid, func, led_index, now_ms, rand_trigger, rand_span, base_color,
                 output ready);
endinterface

interface ltfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  led_out_index;
   logic [23:0] led_color;

   modport source (output valid, led_out_index, led_color, input ready);
   modport sink (input valid, led_out_index, led_color, output ready);
endinterface

`default_nettype wire

@@ rtl/ltfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ltfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

@@ rtl/ltfs_div.sv @@
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Dividend must be below 256 times the divisor. No dependencies.
`default_nettype none

module ltfs_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [23:0] dividend,
   input  wire logic [15:0] divisor,
   output      logic [7:0]  quotient,
   output      logic        done
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  step_ff, step_in;
   logic [23:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [7:0]  q_ff, q_in;
   logic [23:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      trial   = {8'd0, dvs_ff} << step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd7;
         rem_in  = dividend;
         dvs_in  = divisor;
         q_in    = 8'd0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in        = rem_ff - trial;
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;
endmodule

`default_nettype wire

@@ rtl/led_twinkle_fade_sequencer_unit.sv @@
// LED twinkle/fade sequencer: per-LED phase state in RAM, CSR block, sequencer.
// Update: LOAD, TRIG, EVAL, plus MUL, DIV, BRIGHT for a fade through the 8-step
// divider, then SCALE, which waits on a pending response; next request taken once
// back in idle. Restart: state written at acceptance, one per cycle while idle.
// Reset (sync): sequencer idle, CSRs zero, per-LED valid bits cleared at once.
// Depends on ltfs_pkg, ltfs_if, ltfs_ram, ltfs_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module led_twinkle_fade_sequencer_unit #(
   parameter int NUM_LEDS = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ltfs_req_if.sink                             req,
   ltfs_rsp_if.source                           rsp,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ltfs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output      logic [31:0]                     prdata,
   output      logic                            pready
);
   localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [8:0] LED_LIMIT = 9'(NUM_LEDS);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_TRIG, S_EVAL, S_MUL, S_DIV, S_BRIGHT, S_SCALE
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] blink_threshold_ff, blink_threshold_in;
   logic [15:0] off_base_ms_ff, off_base_ms_in;
   logic [15:0] on_base_ms_ff, on_base_ms_in;
   logic [15:0] random_span_ms_ff, random_span_ms_in;
   logic [7:0]  min_bright_ff, min_bright_in;
   logic [15:0] restart_ms_ff, restart_ms_in;

   logic [NUM_LEDS-1:0] valid_ff, valid_in;

   logic [7:0]  idx_ff, idx_in;
   logic [31:0] now_ff, now_in;
   logic [15:0] rtrig_ff, rtrig_in;
   logic [15:0] rspan_ff, rspan_in;
   logic [23:0] color_ff, color_in;
   logic [1:0]  ph_ff, ph_in;
   logic [31:0] last_ff, last_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] extra_ff, extra_in;
   logic [15:0] delta_ff, delta_in;
   logic        down_ff, down_in;
   logic [7:0]  bright_ff, bright_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_index_ff, rsp_index_in;
   logic [23:0] rsp_color_ff, rsp_color_in;

   logic                 accept, csr_we, scale_go;
   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr;
   ltfs_pkg::entry_type  ram_wr_data, ram_rd_data, loaded;
   logic [31:0]          extra_prod, delta;
   logic [23:0]          dividend, span_prod;
   logic [7:0]           span, quotient;
   logic                 div_start, div_done;

   ltfs_ram #(
      .WIDTH($bits(ltfs_pkg::entry_type)),
      .DEPTH(NUM_LEDS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req.led_index[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   ltfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (len_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign pready    = 1'b1;
   assign csr_we    = psel && penable && pwrite;
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign scale_go  = (state_ff == S_SCALE) && (!rsp_valid_ff || rsp.ready);
   assign span      = 8'd255 - min_bright_ff;
   assign span_prod = {16'd0, span} * {8'd0, delta_ff};
   assign dividend  = span_prod + (down_ff ? {8'd0, len_ff - 16'd1} : 24'd0);
   assign div_start = (state_ff == S_MUL);
   assign extra_prod = {16'd0, rspan_ff} * {16'd0, random_span_ms_ff};
   assign loaded    = valid_ff[idx_ff[AW-1:0]] ? ram_rd_data : ltfs_pkg::ENTRY_RESET;
   assign delta     = now_ff - last_ff;

   always_comb begin
      case (paddr[4:2])
         ltfs_pkg::REG_BLINK_THRESHOLD: prdata = {16'd0, blink_threshold_ff};
         ltfs_pkg::REG_OFF_BASE_MS:     prdata = {16'd0, off_base_ms_ff};
         ltfs_pkg::REG_ON_BASE_MS:      prdata = {16'd0, on_base_ms_ff};
         ltfs_pkg::REG_RANDOM_SPAN_MS:  prdata = {16'd0, random_span_ms_ff};
         ltfs_pkg::REG_MIN_BRIGHT:      prdata = {24'd0, min_bright_ff};
         ltfs_pkg::REG_RESTART_MS:      prdata = {16'd0, restart_ms_ff};
         default:                       prdata = 32'd0;
      endcase
   end

   always_comb begin
      blink_threshold_in = blink_threshold_ff;
      off_base_ms_in     = off_base_ms_ff;
      on_base_ms_in      = on_base_ms_ff;
      random_span_ms_in  = random_span_ms_ff;
      min_bright_in      = min_bright_ff;
      restart_ms_in      = restart_ms_ff;
      if (csr_we) begin
         case (paddr[4:2])
            ltfs_pkg::REG_BLINK_THRESHOLD: blink_threshold_in = pwdata[15:0];
            ltfs_pkg::REG_OFF_BASE_MS:     off_base_ms_in     = pwdata[15:0];
            ltfs_pkg::REG_ON_BASE_MS:      on_base_ms_in      = pwdata[15:0];
            ltfs_pkg::REG_RANDOM_SPAN_MS:  random_span_ms_in  = pwdata[15:0];
            ltfs_pkg::REG_MIN_BRIGHT:      min_bright_in      = pwdata[7:0];
            ltfs_pkg::REG_RESTART_MS:      restart_ms_in      = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      rtrig_in     = rtrig_ff;
      rspan_in     = rspan_ff;
      color_in     = color_ff;
      ph_in        = ph_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      extra_in     = extra_ff;
      delta_in     = delta_ff;
      down_in      = down_ff;
      bright_in    = bright_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_color_in = rsp_color_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_addr  = idx_ff[AW-1:0];
      ram_wr_data  = '{phase: ph_ff, last_ms: last_ff, length_ms: len_ff};

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && ({1'b0, req.led_index} < LED_LIMIT)) begin
               idx_in   = req.led_index;
               now_in   = req.now_ms;
               rtrig_in = req.rand_trigger;
               rspan_in = req.rand_span;
               color_in = req.base_color;
               if (req.func) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = req.led_index[AW-1:0];
                  ram_wr_data = '{phase: ltfs_pkg::PH_UP, last_ms: req.now_ms,
                                  length_ms: restart_ms_ff};
                  valid_in[req.led_index[AW-1:0]] = 1'b1;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            ph_in    = loaded.phase;
            last_in  = loaded.last_ms;
            len_in   = loaded.length_ms;
            extra_in = extra_prod[31:16];
            state_in = S_TRIG;
         end
         S_TRIG: begin
            if ((ph_ff == ltfs_pkg::PH_STEADY) && (rtrig_ff < blink_threshold_ff)) begin
               ph_in   = ltfs_pkg::PH_DOWN;
               last_in = now_ff;
               len_in  = off_base_ms_ff + extra_ff;
            end
            state_in = S_EVAL;
         end
         S_EVAL: begin
            delta_in  = delta[15:0];
            bright_in = 8'd255;
            state_in  = S_SCALE;
            case (ph_ff)
               ltfs_pkg::PH_DOWN: begin
                  if (delta > {16'd0, len_ff}) begin
                     ph_in     = ltfs_pkg::PH_UP;
                     last_in   = now_ff;
                     len_in    = on_base_ms_ff + extra_ff;
                     bright_in = min_bright_ff;
                  end else if (len_ff != 16'd0) begin
                     down_in  = 1'b1;
                     state_in = S_MUL;
                  end
               end
               ltfs_pkg::PH_UP: begin
                  if (delta > {16'd0, len_ff}) begin
                     ph_in   = ltfs_pkg::PH_STEADY;
                     last_in = now_ff;
                  end else if (len_ff != 16'd0) begin
                     down_in  = 1'b0;
                     state_in = S_MUL;
                  end else begin
                     bright_in = min_bright_ff;
                  end
               end
               default: ;
            endcase
            ram_wr_en   = 1'b1;
            ram_wr_data = '{phase: ph_in, last_ms: last_in, length_ms: len_in};
            valid_in[idx_ff[AW-1:0]] = 1'b1;
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_BRIGHT;
            end
         end
         S_BRIGHT: begin
            bright_in = down_ff ? (8'd255 - quotient) : (min_bright_ff + quotient);
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            if (scale_go) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_color_in = {ltfs_pkg::scale_channel(color_ff[23:16], bright_ff),
                               ltfs_pkg::scale_channel(color_ff[15:8], bright_ff),
                               ltfs_pkg::scale_channel(color_ff[7:0], bright_ff)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         valid_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
         blink_threshold_ff <= 16'd0;
         off_base_ms_ff     <= 16'd0;
         on_base_ms_ff      <= 16'd0;
         random_span_ms_ff  <= 16'd0;
         min_bright_ff      <= 8'd0;
         restart_ms_ff      <= 16'd0;
      end else begin
         state_ff           <= state_in;
         valid_ff           <= valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         blink_threshold_ff <= blink_threshold_in;
         off_base_ms_ff     <= off_base_ms_in;
         on_base_ms_ff      <= on_base_ms_in;
         random_span_ms_ff  <= random_span_ms_in;
         min_bright_ff      <= min_bright_in;
         restart_ms_ff      <= restart_ms_in;
      end
      idx_ff       <= idx_in;
      now_ff       <= now_in;
      rtrig_ff     <= rtrig_in;
      rspan_ff     <= rspan_in;
      color_ff     <= color_in;
      ph_ff        <= ph_in;
      last_ff      <= last_in;
      len_ff       <= len_in;
      extra_ff     <= extra_in;
      delta_ff     <= delta_in;
      down_ff      <= down_in;
      bright_ff    <= bright_in;
      rsp_index_ff <= rsp_index_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.led_out_index = rsp_index_ff;
   assign rsp.led_color     = rsp_color_ff;

   `LTFS_ASSERT_IMPLIES(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV)
   `LTFS_ASSERT_NEXT(a_mul_starts_div, clock, reset, state_ff == S_MUL, state_ff == S_DIV)
   `LTFS_ASSERT_NEXT(a_scale_loads_rsp, clock, reset, scale_go, rsp_valid_ff)
   `LTFS_ASSERT_IMPLIES(a_ram_wr_slot, clock, reset, ram_wr_en, state_ff <= S_EVAL)
endmodule

`default_nettype wire
